>>> rtl/svdg_pkg.sv
// ----------------------------------------------------------------------------
// svdg_pkg
// Shared constants, command codes and conversion tables for the volume core.
// ----------------------------------------------------------------------------
package svdg_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic signed [15:0] STEP_DB   = 16'sd1541;
    localparam logic        [9:0]  FRAC_MUL  = 10'd680;
    localparam logic        [14:0] UNITY     = 15'h4000;
    localparam logic        [14:0] FULL_SCALE = 15'h7fff;
    localparam logic signed [15:0] SILENT_DB = 16'sh8000;
    localparam logic signed [15:0] RESET_LEVEL = -16'sd1541;
    localparam logic        [14:0] RESET_GAIN  = 15'd8192;

    typedef enum logic [1:0] {
        FUNC_GLOBAL_MUTE = 2'd0,
        FUNC_CHAN_MUTE   = 2'd1,
        FUNC_CHAN_VOLUME = 2'd2,
        FUNC_NONE        = 2'd3
    } func_t;

    function automatic logic [7:0] exp_tab(input logic [7:0] i);
        logic [7:0] t [256];
        t = '{
        8'h00,8'h01,8'h01,8'h02,8'h03,8'h03,8'h04,8'h05,8'h06,8'h06,8'h07,8'h08,8'h08,8'h09,8'h0a,8'h0b,
        8'h0b,8'h0c,8'h0d,8'h0e,8'h0e,8'h0f,8'h10,8'h10,8'h11,8'h12,8'h13,8'h13,8'h14,8'h15,8'h16,8'h16,
        8'h17,8'h18,8'h19,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'h1d,8'h1e,8'h1f,8'h20,8'h20,8'h21,8'h22,8'h23,
        8'h24,8'h24,8'h25,8'h26,8'h27,8'h28,8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2c,8'h2d,8'h2e,8'h2f,8'h30,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h3a,8'h3b,8'h3c,8'h3d,
        8'h3e,8'h3f,8'h40,8'h41,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h48,8'h49,8'h4a,8'h4b,
        8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,
        8'h5b,8'h5c,8'h5d,8'h5e,8'h5e,8'h5f,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
        8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,
        8'h7a,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h87,8'h88,8'h89,8'h8a,
        8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,8'h93,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,
        8'h9c,8'h9d,8'h9f,8'ha0,8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,
        8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hbc,8'hbd,8'hbe,8'hbf,8'hc0,
        8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc8,8'hc9,8'hca,8'hcb,8'hcd,8'hce,8'hcf,8'hd0,8'hd2,8'hd3,8'hd4,
        8'hd6,8'hd7,8'hd8,8'hd9,8'hdb,8'hdc,8'hdd,8'hde,8'he0,8'he1,8'he2,8'he4,8'he5,8'he6,8'he8,8'he9,
        8'hea,8'hec,8'hed,8'hee,8'hf0,8'hf1,8'hf2,8'hf4,8'hf5,8'hf6,8'hf8,8'hf9,8'hfa,8'hfc,8'hfd,8'hff};
        return t[i];
    endfunction

    function automatic logic [7:0] log_tab(input logic [7:0] i);
        logic [7:0] t [256];
        t = '{
        8'h00,8'h01,8'h03,8'h04,8'h06,8'h07,8'h09,8'h0a,8'h0b,8'h0d,8'h0e,8'h10,8'h11,8'h12,8'h14,8'h15,
        8'h16,8'h18,8'h19,8'h1a,8'h1c,8'h1d,8'h1e,8'h20,8'h21,8'h22,8'h24,8'h25,8'h26,8'h28,8'h29,8'h2a,
        8'h2c,8'h2d,8'h2e,8'h2f,8'h31,8'h32,8'h33,8'h34,8'h36,8'h37,8'h38,8'h39,8'h3b,8'h3c,8'h3d,8'h3e,
        8'h3f,8'h41,8'h42,8'h43,8'h44,8'h45,8'h47,8'h48,8'h49,8'h4a,8'h4b,8'h4d,8'h4e,8'h4f,8'h50,8'h51,
        8'h52,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h5c,8'h5d,8'h5e,8'h5f,8'h60,8'h61,8'h62,8'h63,
        8'h64,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,
        8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,
        8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,8'ha0,8'ha1,8'ha2,8'ha3,8'ha4,
        8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb2,
        8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,8'hc0,8'hc0,
        8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hcb,8'hcb,8'hcc,8'hcd,8'hce,
        8'hcf,8'hd0,8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd8,8'hd9,8'hda,8'hdb,
        8'hdc,8'hdc,8'hdd,8'hde,8'hdf,8'he0,8'he0,8'he1,8'he2,8'he3,8'he4,8'he4,8'he5,8'he6,8'he7,8'he7,
        8'he8,8'he9,8'hea,8'hea,8'heb,8'hec,8'hed,8'hee,8'hee,8'hef,8'hf0,8'hf1,8'hf1,8'hf2,8'hf3,8'hf4,
        8'hf4,8'hf5,8'hf6,8'hf7,8'hf7,8'hf8,8'hf9,8'hf9,8'hfa,8'hfb,8'hfc,8'hfc,8'hfd,8'hfe,8'hff,8'hff};
        return t[i];
    endfunction

endpackage

>>> rtl/stereo_volume_db_to_gain_core.sv
// ----------------------------------------------------------------------------
// stereo_volume_db_to_gain_core
// Two-channel volume and mute unit with iterative dB to linear conversion.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command per transaction (global mute,
//   channel mute or channel volume). The master channel returns one result
//   per command: the packed gain word, plus the stored level and linear gain
//   of the addressed channel.
//   Mute commands and unchanged volumes go from decode straight to the
//   store state, which loads the result. A volume change runs a shared
//   17-bit adder: it adds 1541 until the level is non-negative (s adds,
//   up to 22), does one table lookup, seeds the normalization, shifts the
//   gain left (k shifts, equal to s), adds the final log, multiplies and
//   scales, and stores. A shift of 15 or more gives a zero gain, skips the
//   scale step and goes straight to the store.
//   s_tready is low while a command is being worked or its result waits;
//   the block is ready again in the cycle after the result is taken.
//   When the receiver stalls, the result is held in the output register.
//   Reset restores -1541 level and 8192 gain on both channels, clears the
//   mutes and leaves the block ready.
// ----------------------------------------------------------------------------
module stereo_volume_db_to_gain_core
    import svdg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] func, [2] channel, [3] mute_flag, [19:4] volume_db, zero fill
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] gain_word, [47:32] level_db, [62:48] gain_linear, zero fill
    output logic [63:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ADD, S_LOOK, S_NORM, S_SCALE, S_STORE, S_OUT
    } state_t;

    state_t              state_reg;
    logic                gmute_reg;
    logic [NUM_CHANNELS-1:0] cmute_reg;
    logic signed [15:0]  level_reg [NUM_CHANNELS];
    logic [14:0]         gain_reg  [NUM_CHANNELS];
    logic [1:0]          func_reg;
    logic                ch_reg;
    logic                flag_reg;
    logic signed [16:0]  acc_reg;   // dB accumulator, then log sum
    logic [4:0]          shift_reg;
    logic [14:0]         g_reg;     // new gain
    logic [14:0]         n_reg;     // normalized gain
    logic signed [26:0]  prod_reg;
    logic signed [15:0]  newlvl_reg;
    logic [63:0]         out_reg;

    logic                valid_ch;
    logic [CH_W-1:0]     ch_idx;
    logic [25:0]         frac_prod;
    logic [7:0]          et;
    logic [14:0]         gfull;
    logic [15:0]         gw [2];

    assign valid_ch = (32'(ch_reg) < NUM_CHANNELS);
    assign ch_idx   = CH_W'(ch_reg);
    assign frac_prod = 26'(acc_reg[15:0]) * 26'(FRAC_MUL);
    assign et       = exp_tab(frac_prod[19:12]);
    assign gfull    = {1'b1, et, 6'd0} | {7'd0, et} >> 2 | UNITY;

    // form each channel's masked gain
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            gw[i] = '0;
            if (i < NUM_CHANNELS && !gmute_reg && !cmute_reg[i[CH_W-1:0]])
                gw[i] = {1'b0, gain_reg[i[CH_W-1:0]]};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    // sequencer, stored state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            gmute_reg <= 1'b0;
            cmute_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                level_reg[i] <= RESET_LEVEL;
                gain_reg[i]  <= RESET_GAIN;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= s_tdata[1:0];
                        ch_reg    <= s_tdata[2];
                        flag_reg  <= s_tdata[3];
                        acc_reg   <= 17'(signed'(s_tdata[19:4]));
                        shift_reg <= '0;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= S_STORE;
                    unique case (func_t'(func_reg))
                        FUNC_GLOBAL_MUTE: gmute_reg <= flag_reg;
                        FUNC_CHAN_MUTE: if (valid_ch) cmute_reg[ch_idx] <= flag_reg;
                        FUNC_CHAN_VOLUME: begin
                            if (valid_ch && level_reg[ch_idx] != acc_reg[15:0]) begin
                                if (acc_reg[15:0] == SILENT_DB) begin
                                    g_reg <= '0;
                                    state_reg <= S_NORM;
                                end else if (acc_reg >= 17'(STEP_DB)) begin
                                    g_reg <= FULL_SCALE;
                                    state_reg <= S_NORM;
                                end else begin
                                    state_reg <= S_ADD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_ADD: begin
                    // add one octave per cycle until non-negative
                    if (acc_reg < 0) begin
                        acc_reg   <= acc_reg + 17'(STEP_DB);
                        shift_reg <= shift_reg + 5'd1;
                    end else begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    g_reg <= (shift_reg >= 5'd15) ? '0 : gfull >> shift_reg;
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    // gain back to dB: normalization is seeded on entry
                    if (state_reg == S_NORM && shift_reg != 5'd31) begin
                        n_reg     <= g_reg;
                        acc_reg   <= '0;
                        shift_reg <= 5'd31;
                    end else if (n_reg == '0) begin
                        newlvl_reg <= SILENT_DB;
                        shift_reg  <= 5'd2;
                        state_reg  <= S_STORE;
                    end else if (n_reg < UNITY) begin
                        n_reg   <= n_reg << 1;
                        acc_reg <= acc_reg - 17'sd256;
                    end else begin
                        acc_reg   <= acc_reg + 17'(log_tab(n_reg[13:6]));
                        shift_reg <= '0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (shift_reg == '0) begin
                        prod_reg  <= 27'(acc_reg) * 27'(STEP_DB);
                        shift_reg <= 5'd1;
                    end else begin
                        newlvl_reg <= 16'(prod_reg >>> 8);
                        shift_reg  <= 5'd2;
                        state_reg  <= S_STORE;
                    end
                end
                S_STORE: begin
                    // commit a converted volume first, then load the result
                    if (shift_reg == 5'd2) begin
                        level_reg[ch_idx] <= newlvl_reg;
                        gain_reg[ch_idx]  <= g_reg;
                        shift_reg <= '0;
                    end else begin
                        out_reg <= {1'b0, valid_ch ? gain_reg[ch_idx] : 15'd0,
                                    valid_ch ? level_reg[ch_idx] : 16'd0,
                                    gw[1], gw[0]};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/svdg_checker.sv
// ----------------------------------------------------------------------------
// svdg_checker
// Port-level checks for the volume core, bound to the top level.
// ----------------------------------------------------------------------------
module svdg_checker
    import svdg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    // never ready while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    // an accepted command leaves the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    // spare bit of the result stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[63]) else $error("pad bit set");
endmodule

bind stereo_volume_db_to_gain_core svdg_checker u_svdg_checker (.*);

>>> dv/stereo_volume_db_to_gain_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_volume_db_to_gain_core_tb
// Self-checking bench for the stereo volume core. A directed table covers
// reset values, every command code, dB extremes and the conversion edges.
// Random commands follow, mostly volume sets near the useful range, under
// three idle patterns. Every result is checked against a built-in model.
// ----------------------------------------------------------------------------
module stereo_volume_db_to_gain_core_tb;
    import svdg_pkg::*;

    typedef struct packed {
        logic [31:0] gain_word;
        logic [15:0] level_db;
        logic [14:0] gain_linear;
    } vol_result_t;

    typedef struct {
        func_t       func;
        logic        channel;
        logic        mute_flag;
        logic [15:0] volume_db;
        logic        has_fixed;
        vol_result_t fixed;
    } cmd_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;

    stereo_volume_db_to_gain_core uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Model state
    logic        mdl_gmute;
    logic        mdl_cmute [2];
    logic [15:0] mdl_level [2];
    logic [14:0] mdl_gain  [2];

    vol_result_t want_q [$];
    int          errors = 0;
    int          src_idle = 11, dst_idle = 50;
    int          n_vol = 0, n_mute = 0;

    function automatic logic [14:0] db_to_lin(logic signed [15:0] db);
        int v, sh;
        logic [7:0] t;
        logic [14:0] g;
        v = db;
        sh = 0;
        if (db == SILENT_DB) return 15'd0;
        if (v >= 1541) return FULL_SCALE;
        while (v < 0) begin
            v += 1541;
            sh++;
        end
        t = exp_tab(8'((v * 680) >> 12));
        g = {1'b0, 14'd0} | ({7'd0, t} << 6) | {7'd0, t >> 2} | UNITY;
        if (sh >= 15) return 15'd0;
        return g >> sh;
    endfunction

    function automatic logic [15:0] lin_to_db(logic [14:0] gain);
        int l;
        int unsigned g;
        l = 0;
        g = gain;
        if (g == 0) return SILENT_DB;
        while (g < 32'h4000) begin
            g <<= 1;
            l -= 256;
        end
        l += log_tab(8'(g >> 6));
        return 16'(((l * 1541) + (1 << 24)) >>> 8) - 16'h0;
    endfunction

    function automatic logic [15:0] active_lin(int ch);
        if (mdl_gmute || mdl_cmute[ch]) return 16'd0;
        return {1'b0, mdl_gain[ch]};
    endfunction

    function automatic vol_result_t apply_cmd(func_t f, logic ch, logic fl, logic [15:0] db);
        vol_result_t r;
        case (f)
            FUNC_GLOBAL_MUTE: mdl_gmute = fl;
            FUNC_CHAN_MUTE: mdl_cmute[ch] = fl;
            FUNC_CHAN_VOLUME: begin
                if (mdl_level[ch] != db) begin
                    mdl_gain[ch]  = db_to_lin(db);
                    mdl_level[ch] = lin_to_db(mdl_gain[ch]);
                end
            end
            default: ;
        endcase
        r.gain_word   = {active_lin(1), active_lin(0)};
        r.level_db    = mdl_level[ch];
        r.gain_linear = mdl_gain[ch];
        return r;
    endfunction

    // Drive one command and queue its expectation
    task automatic send_cmd(func_t f, logic ch, logic fl, logic [15:0] db,
                            logic fixed_ok, vol_result_t fixed);
        vol_result_t r;
        while (src_idle > 0 && $urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'd0, db, fl, ch, 2'(f)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_cmd(f, ch, fl, db);
        if (fixed_ok && r !== fixed) begin
            $display("%0t table row disagrees: table %h model %h", $time, fixed, r);
            errors++;
        end
        want_q.push_back(r);
        if (f == FUNC_CHAN_VOLUME) n_vol++; else n_mute++;
    endtask

    // Receiver: random backpressure and result check
    always @(posedge aclk) begin
        vol_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.gain_word   = m_tdata[31:0];
            got.level_db    = m_tdata[47:32];
            got.gain_linear = m_tdata[62:48];
            if (want_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = want_q.pop_front();
                if (got.gain_word !== exp_r.gain_word) begin
                    $display("%0t gain_word exp %h got %h", $time,
                             exp_r.gain_word, got.gain_word);
                    errors++;
                end
                if (got.level_db !== exp_r.level_db) begin
                    $display("%0t level_db exp %h got %h", $time,
                             exp_r.level_db, got.level_db);
                    errors++;
                end
                if (got.gain_linear !== exp_r.gain_linear) begin
                    $display("%0t gain_linear exp %h got %h", $time,
                             exp_r.gain_linear, got.gain_linear);
                    errors++;
                end
                if (m_tdata[63] !== 1'b0) begin
                    $display("%0t pad bit exp 0 got %b", $time, m_tdata[63]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [15:0] rand_db();
        int k;
        k = $urandom_range(99);
        if (k < 60) return 16'(-int'($urandom_range(34000)) + 1600);
        if (k < 70) return 16'(1541 + $urandom_range(3));
        if (k < 80) return 16'(-1541 * $urandom_range(22) + $urandom_range(2) - 1);
        if (k < 85) return SILENT_DB;
        return 16'($urandom);
    endfunction

    initial begin
        cmd_row_t rows [$];
        cmd_row_t rw;
        vol_result_t none;
        func_t f;
        int k;
        logic ch;
        none = '0;
        mdl_gmute = 0;
        for (int i = 0; i < 2; i++) begin
            mdl_cmute[i] = 0;
            mdl_level[i] = RESET_LEVEL;
            mdl_gain[i]  = RESET_GAIN;
        end
        // func, channel, flag, dB, fixed?, fixed result
        rows.push_back('{FUNC_NONE, 0, 0, 16'h0000, 1,
                        '{32'h2000_2000, 16'hf9fb, 15'd8192}});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'hf9fb, 1,
                        '{32'h2000_2000, 16'hf9fb, 15'd8192}});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 0, 16'h7fff, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'h8000, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 1, 16'd1541, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 0, 16'd1540, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'd0, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'hffff, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 0, 16'h8001, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 0, 16'(-1541*15), 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'(-1541*14), 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 0, 16'(-1541*14), 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 0, 0, 16'hfa00, 0, none});
        rows.push_back('{FUNC_CHAN_MUTE, 0, 1, 16'hffff, 0, none});
        rows.push_back('{FUNC_CHAN_MUTE, 1, 1, 16'h0000, 0, none});
        rows.push_back('{FUNC_CHAN_MUTE, 0, 0, 16'h0000, 0, none});
        rows.push_back('{FUNC_GLOBAL_MUTE, 1, 1, 16'h5555, 0, none});
        rows.push_back('{FUNC_NONE, 0, 1, 16'haaaa, 0, none});
        rows.push_back('{FUNC_GLOBAL_MUTE, 0, 0, 16'h0000, 0, none});
        rows.push_back('{FUNC_CHAN_MUTE, 1, 0, 16'h0000, 0, none});
        rows.push_back('{FUNC_CHAN_VOLUME, 1, 1, 16'h0100, 0, none});

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) begin
            rw = rows[i];
            send_cmd(rw.func, rw.channel, rw.mute_flag, rw.volume_db,
                     rw.has_fixed, rw.fixed);
        end

        // Random commands, three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 11 : (ph == 1) ? 50 : 0;
            dst_idle = (ph == 0) ? 50 : (ph == 1) ? 11 : 0;
            for (int n = 0; n < 300; n++) begin
                k  = $urandom_range(99);
                ch = 1'($urandom);
                f  = (k < 65) ? FUNC_CHAN_VOLUME : (k < 80) ? FUNC_CHAN_MUTE :
                     (k < 92) ? FUNC_GLOBAL_MUTE : FUNC_NONE;
                if (f == FUNC_CHAN_VOLUME && $urandom_range(9) == 0)
                    send_cmd(f, ch, 1'($urandom), mdl_level[ch], 0, none);
                else
                    send_cmd(f, ch, 1'($urandom), rand_db(), 0, none);
            end
        end
        s_tvalid <= 0;

        while (want_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d volume and %0d mute/other commands, three idle patterns.",
                 n_vol, n_mute);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> stereo_volume_db_to_gain_core.f
rtl/svdg_pkg.sv
rtl/stereo_volume_db_to_gain_core.sv
rtl/svdg_checker.sv
dv/stereo_volume_db_to_gain_core_tb.sv
